// ----- hdl/clkrep_pkg.sv -----
// shared constants, state type and slot index helpers for the clock replacement slot cache
package clkrep_pkg;

   localparam int NUM_SLOTS  = 5;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int BIN_W      = 16;
   localparam int RSP_SLOT_W = 3;

   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [CNT_W-1:0]  scan_cnt_type;
   typedef logic [BIN_W-1:0]  bin_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_VICTIM
   } state_type;

   function automatic slot_idx_type slot_next(input slot_idx_type idx);
      slot_idx_type res;
      if (idx == SLOT_W'(NUM_SLOTS - 1)) begin
         res = '0;
      end else begin
         res = idx + SLOT_W'(1);
      end
      return res;
   endfunction

   function automatic logic [RSP_SLOT_W-1:0] slot_to_rsp(input slot_idx_type idx);
      logic [SLOT_W+RSP_SLOT_W-1:0] wide;
      wide = {{RSP_SLOT_W{1'b0}}, idx};
      return wide[RSP_SLOT_W-1:0];
   endfunction

endpackage

// ----- hdl/clock_replacement_slot_cache.sv -----
// top level: clock second chance slot cache with tags in ram and a sequencing state machine
// one transaction at a time; busy is high from the accepting edge until the result strobe
// hit: the scan checks slots from zero upward and stops at the first valid matching tag
// miss: the sweep clears each set reference bit it passes, then the victim slot is filled
// the tag scan reads one ram entry per cycle; the sweep steps the hand one slot per cycle
// synchronous reset empties all slots, clears reference bits and puts the hand at slot zero
module clock_replacement_slot_cache
   import clkrep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [BIN_W-1:0]      req_bin,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [RSP_SLOT_W-1:0] rsp_slot,
   output logic                  rsp_evicted_valid,
   output logic [BIN_W-1:0]      rsp_evicted_bin
);

   state_type              state_ff, state_in;
   bin_type                bin_ff, bin_in;
   scan_cnt_type           scan_ff, scan_in;
   logic                   chk_en_ff, chk_en_in;
   slot_idx_type           chk_idx_ff, chk_idx_in;
   slot_idx_type           hand_ff, hand_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [NUM_SLOTS-1:0]   ref_ff, ref_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [RSP_SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                   rsp_ev_valid_ff, rsp_ev_valid_in;
   bin_type                rsp_ev_bin_ff, rsp_ev_bin_in;

   logic                   ram_we;
   slot_idx_type           ram_waddr;
   slot_idx_type           ram_raddr;
   bin_type                ram_rdata;
   logic                   tag_match;

   clkrep_ram #(
      .WIDTH (BIN_W),
      .DEPTH (NUM_SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (bin_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign tag_match = chk_en_ff && valid_ff[chk_idx_ff] && (ram_rdata == bin_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         chk_en_ff     <= 1'b0;
         hand_ff       <= '0;
         valid_ff      <= '0;
         ref_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         chk_en_ff     <= chk_en_in;
         hand_ff       <= hand_in;
         valid_ff      <= valid_in;
         ref_ff        <= ref_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff          <= bin_in;
      chk_idx_ff      <= chk_idx_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_bin_ff   <= rsp_ev_bin_in;
   end

   always_comb begin
      state_in        = state_ff;
      bin_in          = bin_ff;
      scan_in         = scan_ff;
      chk_en_in       = 1'b0;
      chk_idx_in      = chk_idx_ff;
      hand_in         = hand_ff;
      valid_in        = valid_ff;
      ref_in          = ref_ff;
      rsp_strobe_in   = 1'b0;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_bin_in   = rsp_ev_bin_ff;
      ram_we          = 1'b0;
      ram_waddr       = hand_ff;
      ram_raddr       = scan_ff[SLOT_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in   = req_bin;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_idx_in = scan_ff[SLOT_W-1:0];
            chk_en_in  = (scan_ff != CNT_W'(NUM_SLOTS));
            if (scan_ff != CNT_W'(NUM_SLOTS)) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (tag_match) begin
               ref_in[chk_idx_ff] = 1'b1;
               rsp_strobe_in      = 1'b1;
               rsp_hit_in         = 1'b1;
               rsp_slot_in        = slot_to_rsp(chk_idx_ff);
               rsp_ev_valid_in    = 1'b0;
               rsp_ev_bin_in      = '0;
               state_in           = ST_IDLE;
            end else if (scan_ff == CNT_W'(NUM_SLOTS)) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            ram_raddr = hand_ff;
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
               hand_in         = slot_next(hand_ff);
            end else begin
               state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            ram_we            = 1'b1;
            rsp_strobe_in     = 1'b1;
            rsp_hit_in        = 1'b0;
            rsp_slot_in       = slot_to_rsp(hand_ff);
            rsp_ev_valid_in   = valid_ff[hand_ff];
            rsp_ev_bin_in     = valid_ff[hand_ff] ? ram_rdata : '0;
            valid_in[hand_ff] = 1'b1;
            ref_in[hand_ff]   = 1'b1;
            hand_in           = slot_next(hand_ff);
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_bin   = rsp_ev_bin_ff;

   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= SLOT_W'(NUM_SLOTS - 1))
      else $error("hand out of slot range");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while still working");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_hit_ff) |-> (!rsp_ev_valid_ff && (rsp_ev_bin_ff == '0)))
      else $error("hit reports an eviction");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_victim_ref_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VICTIM) |-> !ref_ff[hand_ff])
      else $error("victim slot has its reference bit set");

endmodule

// ----- hdl/clkrep_ram.sv -----
// generic single write port ram with registered read
module clkrep_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
